FILE: hdl/snfcs_pkg.sv
`timescale 1ns / 1ps
package snfcs_pkg;

  // Default page size and its limits.
  localparam int unsigned PAGE_BYTES_DEF = 256;
  localparam int unsigned POLL_LIMIT_RST = 100000;
  localparam int unsigned CHUNK_W        = 13;

  // Event kinds on the input stream.
  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_WDATA   = 2'd1,
    CMD_RETURN  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Request operations.
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_PROG   = 3'd2;
  localparam logic [2:0] OP_SECTOR = 3'd3;
  localparam logic [2:0] OP_CHIP   = 3'd4;
  localparam logic [2:0] OP_ID     = 3'd5;

  // Flash opcodes.
  localparam logic [7:0] FL_WREN    = 8'h06;
  localparam logic [7:0] FL_RDSR    = 8'h05;
  localparam logic [7:0] FL_RDID    = 8'h9F;
  localparam logic [7:0] FL_READ    = 8'h03;
  localparam logic [7:0] FL_PROG    = 8'h02;
  localparam logic [7:0] FL_SE      = 8'h20;
  localparam logic [7:0] FL_CE      = 8'hC7;
  localparam logic [7:0] FL_DUMMY   = 8'hFF;
  localparam int unsigned CE_FACTOR = 20;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE_CMD, PH_PRE_STAT, PH_POST_CMD, PH_POST_STAT, PH_WREN,
    PH_OPCODE, PH_ADDR, PH_WAIT_DATA, PH_WDATA, PH_RDATA, PH_ID_CMD, PH_ID_DATA
  } phase_t;

  // One classified event between the front and back parts.
  typedef struct packed {
    cmd_t                 cmd;
    logic [2:0]           op;
    logic [23:0]          address;
    logic [24:0]          length;
    logic [7:0]           write_byte;
    logic [7:0]           rx_byte;
    logic                 len_zero;
    logic                 prog_bad;
    logic [CHUNK_W-1:0]   chunk;
  } event_t;

  // One result word.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       need_write_byte;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

FILE: hdl/snfcs_front.sv
`timescale 1ns / 1ps
module snfcs_front import snfcs_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cmd_t         in_cmd,
  input  logic [2:0]   in_op,
  input  logic [23:0]  in_address,
  input  logic [24:0]  in_length,
  input  logic [7:0]   in_write_byte,
  input  logic [7:0]   in_rx_byte,
  output logic         push,
  output event_t       push_event,
  input  logic         q_full
);

  // Page offset by reciprocal multiply: q is the quotient or one less.
  localparam int unsigned RECIP   = (1 << 24) / PAGE_BYTES;
  localparam logic [20:0] RECIP_C = 21'(RECIP);
  localparam logic [24:0] PAGE_25 = 25'(PAGE_BYTES);
  localparam logic [12:0] PAGE_13 = 13'(PAGE_BYTES);

  event_t      ev_a, ev_b, ev_c;
  logic        va, vb, vc;
  logic [20:0] quo_b;
  logic [24:0] qp_c;
  logic        en;
  logic [44:0] prod_a;
  logic [33:0] prod_b;
  logic [24:0] rem_raw, rem;
  logic [12:0] room;

  assign en       = !vc || !q_full;
  assign in_ready = en;
  assign push     = vc && !q_full;

  assign prod_a = 45'(ev_a.address) * 45'(RECIP_C);
  assign prod_b = 34'(quo_b) * 34'(PAGE_13);

  // Three-stage pipeline, all stages move together.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid && (in_cmd != CMD_NONE);
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ev_a.cmd        <= in_cmd;
      ev_a.op         <= in_op;
      ev_a.address    <= in_address;
      ev_a.length     <= in_length;
      ev_a.write_byte <= in_write_byte;
      ev_a.rx_byte    <= in_rx_byte;
      ev_a.len_zero   <= 1'b0;
      ev_a.prog_bad   <= 1'b0;
      ev_a.chunk      <= '0;
      ev_b            <= ev_a;
      quo_b           <= prod_a[44:24];
      ev_c            <= ev_b;
      qp_c            <= prod_b[24:0];
    end
  end

  // Remainder with one correction step, then request classification.
  always_comb begin
    rem_raw = 25'(ev_c.address) - qp_c;
    rem     = (rem_raw >= PAGE_25) ? rem_raw - PAGE_25 : rem_raw;
    room    = PAGE_13 - rem[12:0];
    push_event          = ev_c;
    push_event.len_zero = (ev_c.length == '0);
    push_event.chunk    = (ev_c.length < 25'(room)) ? ev_c.length[CHUNK_W-1:0] : room;
    push_event.prog_bad = (ev_c.length == '0) || (ev_c.length > PAGE_25) ||
                          ((rem + ev_c.length) > PAGE_25);
  end

endmodule

FILE: hdl/snfcs_queue.sv
`timescale 1ns / 1ps
module snfcs_queue import snfcs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_event,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output event_t q_event
);

  // Two-entry queue; entry 0 is the head.
  event_t      slot [2];
  logic [1:0]  fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_event = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot[0] <= (push && fill == 2'd1) ? push_event : slot[1];
      if (push && fill == 2'd2) slot[1] <= push_event;
    end else if (push) begin
      if (fill == 2'd0) slot[0] <= push_event;
      else slot[1] <= push_event;
    end
  end

endmodule

FILE: hdl/snfcs_back.sv
`timescale 1ns / 1ps
module snfcs_back import snfcs_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic        q_valid,
  input  event_t      q_event,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result
);

  localparam logic [24:0] PAGE_25 = 25'(PAGE_BYTES);

  logic [31:0]        poll_limit;
  logic [31:0]        lim1;
  logic [36:0]        lim20;
  phase_t             phase, phase_next;
  logic [2:0]         active_op, active_op_next;
  logic [23:0]        current_address, current_address_next;
  logic [24:0]        bytes_remaining, bytes_remaining_next;
  logic [CHUNK_W-1:0] chunk_remaining, chunk_remaining_next;
  logic [36:0]        poll_count, poll_count_next;
  logic [1:0]         header_index, header_index_next;
  result_t            res;
  logic               has_res;
  logic               post;
  logic [36:0]        pc_inc, limit;
  logic [24:0]        bytes_dec;
  logic [CHUNK_W-1:0] chunk_dec;

  // Poll limit and its derived wait limits.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= 32'(POLL_LIMIT_RST);
      lim1       <= 32'(POLL_LIMIT_RST);
      lim20      <= 37'(POLL_LIMIT_RST) * 37'(CE_FACTOR);
    end else begin
      if (cfg_valid) poll_limit <= cfg_data;
      lim1  <= (poll_limit == '0) ? 32'd1 : poll_limit;
      lim20 <= {lim1, 4'b0} + {2'b0, lim1, 2'b0} + 37'd0;
    end
  end

  assign pop = q_valid && (!out_valid || out_ready);

  // Address byte of the header, high byte first.
  function automatic logic [7:0] addr_byte(input logic [23:0] a, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = a[23:16];
      2'd1:    b = a[15:8];
      default: b = a[7:0];
    endcase
    return b;
  endfunction

  // Sequencer step for one event.
  always_comb begin
    phase_next           = phase;
    active_op_next       = active_op;
    current_address_next = current_address;
    bytes_remaining_next = bytes_remaining;
    chunk_remaining_next = chunk_remaining;
    poll_count_next      = poll_count;
    header_index_next    = header_index;
    res                  = '0;
    has_res              = 1'b0;
    post                 = (phase == PH_POST_CMD) || (phase == PH_POST_STAT);
    pc_inc               = poll_count + 37'd1;
    limit                = (post && active_op == OP_CHIP) ? lim20 : {5'b0, lim1};
    bytes_dec            = bytes_remaining - 25'd1;
    chunk_dec            = chunk_remaining - 1'b1;
    case (q_event.cmd)
      CMD_REQUEST: begin
        if (phase == PH_IDLE) begin
          has_res              = 1'b1;
          active_op_next       = q_event.op;
          current_address_next = q_event.address;
          bytes_remaining_next = q_event.length;
          header_index_next    = 2'd0;
          res.tx_valid         = 1'b1;
          res.tx_byte          = FL_RDSR;
          poll_count_next      = '0;
          phase_next           = PH_PRE_CMD;
          case (q_event.op)
            OP_READ, OP_SECTOR, OP_CHIP: ;
            OP_WRITE: begin
              if (q_event.len_zero) begin
                res        = '0;
                res.done_res = 1'b1;
                res.status = ST_OK;
                phase_next = PH_IDLE;
              end else begin
                chunk_remaining_next = q_event.chunk;
              end
            end
            OP_PROG: begin
              if (q_event.prog_bad) begin
                res          = '0;
                res.done_res = 1'b1;
                res.status   = ST_REJECT;
                phase_next   = PH_IDLE;
              end else begin
                chunk_remaining_next = q_event.length[CHUNK_W-1:0];
              end
            end
            OP_ID: begin
              poll_count_next = poll_count;
              phase_next      = PH_ID_CMD;
              res.tx_byte     = FL_RDID;
            end
            default: begin
              poll_count_next = poll_count;
              res             = '0;
              res.done_res    = 1'b1;
              res.status      = ST_REJECT;
              phase_next      = PH_IDLE;
            end
          endcase
        end
      end
      CMD_WDATA: begin
        if (phase == PH_WAIT_DATA) begin
          has_res       = 1'b1;
          phase_next    = PH_WDATA;
          res.tx_valid  = 1'b1;
          res.tx_byte   = q_event.write_byte;
          res.frame_end = (chunk_remaining == CHUNK_W'(1));
        end
      end
      CMD_RETURN: begin
        if (phase != PH_IDLE && phase != PH_WAIT_DATA) begin
          has_res = 1'b1;
          case (phase)
            PH_PRE_CMD, PH_POST_CMD: begin
              phase_next    = post ? PH_POST_STAT : PH_PRE_STAT;
              res.tx_valid  = 1'b1;
              res.tx_byte   = FL_DUMMY;
              res.frame_end = 1'b1;
            end
            PH_PRE_STAT, PH_POST_STAT: begin
              if (q_event.rx_byte[0]) begin
                poll_count_next = pc_inc;
                if (pc_inc >= limit) begin
                  res.done_res = 1'b1;
                  res.status   = ST_TIMEOUT;
                  phase_next   = PH_IDLE;
                end else begin
                  phase_next   = post ? PH_POST_CMD : PH_PRE_CMD;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = FL_RDSR;
                end
              end else if (!post) begin
                res.tx_valid = 1'b1;
                if (active_op == OP_READ) begin
                  phase_next  = PH_OPCODE;
                  res.tx_byte = FL_READ;
                end else begin
                  phase_next    = PH_WREN;
                  res.tx_byte   = FL_WREN;
                  res.frame_end = 1'b1;
                end
              end else if (active_op == OP_WRITE && bytes_remaining != '0) begin
                // Later chunks start on a page boundary.
                chunk_remaining_next = (bytes_remaining < PAGE_25) ?
                                       bytes_remaining[CHUNK_W-1:0] : PAGE_25[CHUNK_W-1:0];
                poll_count_next = '0;
                phase_next      = PH_PRE_CMD;
                res.tx_valid    = 1'b1;
                res.tx_byte     = FL_RDSR;
              end else begin
                res.done_res = 1'b1;
                res.status   = ST_OK;
                phase_next   = PH_IDLE;
              end
            end
            PH_WREN: begin
              phase_next   = PH_OPCODE;
              res.tx_valid = 1'b1;
              if (active_op == OP_SECTOR) begin
                res.tx_byte = FL_SE;
              end else if (active_op == OP_CHIP) begin
                res.tx_byte   = FL_CE;
                res.frame_end = 1'b1;
              end else begin
                res.tx_byte = FL_PROG;
              end
            end
            PH_OPCODE: begin
              res.tx_valid = 1'b1;
              if (active_op == OP_CHIP) begin
                poll_count_next = '0;
                phase_next      = PH_POST_CMD;
                res.tx_byte     = FL_RDSR;
              end else begin
                header_index_next = 2'd0;
                phase_next        = PH_ADDR;
                res.tx_byte       = addr_byte(current_address, 2'd0);
              end
            end
            PH_ADDR: begin
              if (header_index < 2'd2) begin
                header_index_next = header_index + 2'd1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = addr_byte(current_address, header_index + 2'd1);
                res.frame_end     = (header_index == 2'd1) &&
                                    (active_op == OP_SECTOR ||
                                     (active_op == OP_READ && bytes_remaining == '0));
              end else if (active_op == OP_READ) begin
                if (bytes_remaining == '0) begin
                  res.done_res = 1'b1;
                  res.status   = ST_OK;
                  phase_next   = PH_IDLE;
                end else begin
                  phase_next    = PH_RDATA;
                  res.tx_valid  = 1'b1;
                  res.tx_byte   = FL_DUMMY;
                  res.frame_end = (bytes_remaining == 25'd1);
                end
              end else if (active_op == OP_SECTOR) begin
                poll_count_next = '0;
                phase_next      = PH_POST_CMD;
                res.tx_valid    = 1'b1;
                res.tx_byte     = FL_RDSR;
              end else begin
                phase_next          = PH_WAIT_DATA;
                res.need_write_byte = 1'b1;
              end
            end
            PH_WDATA: begin
              chunk_remaining_next = chunk_dec;
              bytes_remaining_next = bytes_dec;
              current_address_next = current_address + 24'd1;
              if (chunk_dec != '0) begin
                phase_next          = PH_WAIT_DATA;
                res.need_write_byte = 1'b1;
              end else begin
                poll_count_next = '0;
                phase_next      = PH_POST_CMD;
                res.tx_valid    = 1'b1;
                res.tx_byte     = FL_RDSR;
              end
            end
            PH_RDATA: begin
              res.rd_valid         = 1'b1;
              res.rd_byte          = q_event.rx_byte;
              bytes_remaining_next = bytes_dec;
              current_address_next = current_address + 24'd1;
              if (bytes_dec == '0) begin
                res.done_res = 1'b1;
                res.status   = ST_OK;
                phase_next   = PH_IDLE;
              end else begin
                res.tx_valid  = 1'b1;
                res.tx_byte   = FL_DUMMY;
                res.frame_end = (bytes_dec == 25'd1);
              end
            end
            PH_ID_CMD: begin
              header_index_next = 2'd0;
              phase_next        = PH_ID_DATA;
              res.tx_valid      = 1'b1;
              res.tx_byte       = FL_DUMMY;
            end
            PH_ID_DATA: begin
              res.rd_valid = 1'b1;
              res.rd_byte  = q_event.rx_byte;
              if (header_index >= 2'd2) begin
                res.done_res = 1'b1;
                res.status   = ST_OK;
                phase_next   = PH_IDLE;
              end else begin
                header_index_next = header_index + 2'd1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = FL_DUMMY;
                res.frame_end     = (header_index == 2'd1);
              end
            end
            default: has_res = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      active_op       <= '0;
      current_address <= '0;
      bytes_remaining <= '0;
      chunk_remaining <= '0;
      poll_count      <= '0;
      header_index    <= '0;
    end else if (pop) begin
      phase           <= phase_next;
      active_op       <= active_op_next;
      current_address <= current_address_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_remaining <= chunk_remaining_next;
      poll_count      <= poll_count_next;
      header_index    <= header_index_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= pop && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_result <= res;
  end

endmodule

FILE: hdl/spi_nor_flash_command_sequencer_top.sv
`timescale 1ns / 1ps
// An accepted event passes the three-stage multiply pipeline in front, which finds
// the page offset of a request, then a queue, then the output register; throughput is
// one event per cycle unless m_tready stalls, set by the single-step back sequencer.
// Reset (rst, synchronous): sequencer idle, counters zero, poll limit 100000,
// pipeline and queue empty.
module spi_nor_flash_command_sequencer_top import snfcs_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[2:0], address[26:3], length[51:27], write_byte[59:52], rx_byte[67:60]
  input  logic [71:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tx_valid[0], tx_byte[8:1], need_write_byte[9], rd_valid[10], rd_byte[18:11],
  // done_res[19], status[21:20]
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  logic    push, q_full, pop, q_valid;
  event_t  push_event, q_event;
  result_t res;

  assign cfg_ready = 1'b1;

  snfcs_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_cmd(cmd_t'(s_tuser)),
    .in_op(s_tdata[2:0]), .in_address(s_tdata[26:3]), .in_length(s_tdata[51:27]),
    .in_write_byte(s_tdata[59:52]), .in_rx_byte(s_tdata[67:60]),
    .push(push), .push_event(push_event), .q_full(q_full)
  );

  snfcs_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_event(push_event), .full(q_full),
    .pop(pop), .q_valid(q_valid), .q_event(q_event)
  );

  snfcs_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_event(q_event), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_result(res)
  );

  assign m_tdata = {2'b0, res.status, res.done_res, res.rd_byte, res.rd_valid,
                    res.need_write_byte, res.tx_byte, res.tx_valid};
  assign m_tlast = res.frame_end;

endmodule
